@@ sv/kfs_pkg.sv @@
// kfs_pkg: shared types and constants of the k-th fraction selector
`timescale 1ns / 1ps

package kfs_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 16;
    localparam int CNT_W          = 5;

    typedef enum logic [1:0] {
        K_CLEAR    = 2'd0,
        K_APPEND   = 2'd1,
        K_LARGEST  = 2'd2,
        K_SMALLEST = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_ZERO_DEN  = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic mult_en;
        logic commit;
    } t_cell_ctl;

endpackage

@@ sv/kfs_cell.sv @@
// kfs_cell: one slot of the sorted chain, with its cross-multiply compare
`timescale 1ns / 1ps

module kfs_cell #(
    parameter int VALUE_BITS = kfs_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  kfs_pkg::t_cell_ctl           i_ctl,
    input  logic                         i_active,
    input  logic                         i_slot_open,
    input  logic signed [VALUE_BITS:0]   i_new_num_n,
    input  logic signed [VALUE_BITS:0]   i_new_den_n,
    input  logic signed [VALUE_BITS-1:0] i_ins_num,
    input  logic signed [VALUE_BITS-1:0] i_ins_den,
    input  logic                         i_prev_keep,
    input  logic signed [VALUE_BITS-1:0] i_prev_num,
    input  logic signed [VALUE_BITS-1:0] i_prev_den,
    output logic                         o_keep,
    output logic signed [VALUE_BITS-1:0] o_num,
    output logic signed [VALUE_BITS-1:0] o_den
);
    import kfs_pkg::*;

    localparam int PW = 2 * (VALUE_BITS + 1);

    logic signed [VALUE_BITS-1:0] r_num;
    logic signed [VALUE_BITS-1:0] r_den;
    logic signed [PW-1:0]         r_prod_own;
    logic signed [PW-1:0]         r_prod_new;
    logic signed [VALUE_BITS:0]   w_own_n;
    logic signed [VALUE_BITS:0]   w_own_d;

    // bring the held fraction to a positive denominator
    always_comb begin
        if (r_den[VALUE_BITS-1]) begin
            w_own_n = -{r_num[VALUE_BITS-1], r_num};
            w_own_d = -{r_den[VALUE_BITS-1], r_den};
        end else begin
            w_own_n = {r_num[VALUE_BITS-1], r_num};
            w_own_d = {r_den[VALUE_BITS-1], r_den};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mult_en) begin
            r_prod_own <= w_own_n * i_new_den_n;
            r_prod_new <= i_new_num_n * w_own_d;
        end
    end

    // held <= new keeps this slot in place
    assign o_keep = i_active && (r_prod_own <= r_prod_new);

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && i_slot_open && !o_keep) begin
            if (i_prev_keep) begin
                r_num <= i_ins_num;
                r_den <= i_ins_den;
            end else begin
                r_num <= i_prev_num;
                r_den <= i_prev_den;
            end
        end
    end

    assign o_num = r_num;
    assign o_den = r_den;

endmodule

@@ sv/kth_fraction_selector_core.sv @@
// kth_fraction_selector_core: sorted fraction store with rank queries
//
// input channel: i_in_valid / o_in_stall with i_kind, i_numerator,
// i_denominator, i_rank. kinds: clear, append, k-th largest, k-th smallest.
// output channel: o_out_valid / i_out_stall with o_status,
// o_result_numerator, o_result_denominator, o_stored_count; one word out
// for every word in.
// a word is taken in the idle state, where all slots of the cell chain
// form and register their cross products; they compare, shift and answer
// in the exec state, which registers the result and takes no new word.
// the chain holds one item at a time.
// while a result waits under stall the block may take the next word; that
// word holds in the compare step until the output register frees up.
// reset (synchronous, active low) empties the store and drops any result.
// slot contents are not cleared; only slots below the count are ever read.
`timescale 1ns / 1ps

module kth_fraction_selector_core #(
    parameter int CAPACITY   = kfs_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = kfs_pkg::VALUE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_kind,
    input  logic signed [VALUE_BITS-1:0]      i_numerator,
    input  logic signed [VALUE_BITS-1:0]      i_denominator,
    input  logic [kfs_pkg::CNT_W-1:0]         i_rank,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic signed [VALUE_BITS-1:0]      o_result_numerator,
    output logic signed [VALUE_BITS-1:0]      o_result_denominator,
    output logic [kfs_pkg::CNT_W-1:0]         o_stored_count
);
    import kfs_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = (CW > CNT_W) ? CW : CNT_W;

    t_state                       r_state;
    t_state                       n_state;
    t_kind                        r_kind;
    logic signed [VALUE_BITS-1:0] r_num;
    logic signed [VALUE_BITS-1:0] r_den;
    logic [CNT_W-1:0]             r_rank;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;

    logic                         r_out_valid;
    t_status                      r_status;
    logic signed [VALUE_BITS-1:0] r_res_num;
    logic signed [VALUE_BITS-1:0] r_res_den;
    logic [CW-1:0]                r_res_count;

    logic                         w_accept;
    logic                         w_finish;
    t_status                      w_status;
    logic signed [VALUE_BITS-1:0] w_sel_num;
    logic signed [VALUE_BITS-1:0] w_sel_den;
    logic                         w_emit_sel;
    t_cell_ctl                    w_ctl;
    logic [RW-1:0]                w_rank_x;
    logic [RW-1:0]                w_count_x;
    logic [RW-1:0]                w_idx_x;
    logic [CW-1:0]                w_idx;
    logic signed [VALUE_BITS:0]   w_new_num_n;
    logic signed [VALUE_BITS:0]   w_new_den_n;

    logic                         w_keep [CAPACITY+1];
    logic signed [VALUE_BITS-1:0] w_num  [CAPACITY+1];
    logic signed [VALUE_BITS-1:0] w_den  [CAPACITY+1];

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= t_kind'(i_kind);
            r_num  <= i_numerator;
            r_den  <= i_denominator;
            r_rank <= i_rank;
        end
    end

    // the new fraction, positive denominator, straight from the ports
    always_comb begin
        if (i_denominator[VALUE_BITS-1]) begin
            w_new_num_n = -{i_numerator[VALUE_BITS-1], i_numerator};
            w_new_den_n = -{i_denominator[VALUE_BITS-1], i_denominator};
        end else begin
            w_new_num_n = {i_numerator[VALUE_BITS-1], i_numerator};
            w_new_den_n = {i_denominator[VALUE_BITS-1], i_denominator};
        end
    end

    // rank to slot index; slot k sits at chain tap k+1
    always_comb begin
        w_rank_x  = RW'(r_rank);
        w_count_x = RW'(r_count);
        if (r_kind == K_LARGEST) begin
            w_idx_x = w_count_x - w_rank_x;
        end else begin
            w_idx_x = w_rank_x - RW'(1);
        end
        w_idx     = w_idx_x[CW-1:0] + CW'(1);
        w_sel_num = w_num[w_idx];
        w_sel_den = w_den[w_idx];
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        w_status   = ST_OK;
        w_emit_sel = 1'b0;
        w_finish   = 1'b0;
        w_ctl      = '0;
        case (r_state)
            S_IDLE: begin
                w_ctl.mult_en = w_accept;
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                w_finish = !(r_out_valid && i_out_stall);
                case (r_kind)
                    K_CLEAR: begin
                        n_count = '0;
                    end
                    K_APPEND: begin
                        if (r_den == '0) begin
                            w_status = ST_ZERO_DEN;
                        end else if (r_count == CW'(CAPACITY)) begin
                            w_status = ST_FULL;
                        end else begin
                            w_ctl.commit = w_finish;
                            n_count      = r_count + CW'(1);
                        end
                    end
                    default: begin
                        if (w_rank_x == '0 || w_rank_x > w_count_x) begin
                            w_status = ST_NOT_FOUND;
                        end else begin
                            w_emit_sel = 1'b1;
                        end
                    end
                endcase
                if (w_finish) begin
                    n_state = S_IDLE;
                end else begin
                    n_count = r_count;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_status    <= w_status;
            r_res_num   <= w_emit_sel ? w_sel_num : '0;
            r_res_den   <= w_emit_sel ? w_sel_den : '0;
            r_res_count <= n_count;
        end
    end

    // head of the chain: the insert word enters behind a virtual kept slot
    assign w_keep[0] = 1'b1;
    assign w_num[0]  = r_num;
    assign w_den[0]  = r_den;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic w_active;
        logic w_open;

        assign w_active = (CW'(g) < r_count);
        assign w_open   = (CW'(g) <= r_count);

        kfs_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_active    (w_active),
            .i_slot_open (w_open),
            .i_new_num_n (w_new_num_n),
            .i_new_den_n (w_new_den_n),
            .i_ins_num   (r_num),
            .i_ins_den   (r_den),
            .i_prev_keep (w_keep[g]),
            .i_prev_num  ((g == 0) ? r_num : w_num[g]),
            .i_prev_den  ((g == 0) ? r_den : w_den[g]),
            .o_keep      (w_keep[g+1]),
            .o_num       (w_num[g+1]),
            .o_den       (w_den[g+1])
        );
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_status;
    assign o_result_numerator   = r_res_num;
    assign o_result_denominator = r_res_den;
    assign o_stored_count       = CNT_W'(r_res_count);

endmodule
